// ----- design/rcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared constants and types for the row/column permutation table.
// ----------------------------------------------------------------------------
package rcp_pkg;

    // default grid size
    localparam int DEF_ROWS = 1024;
    localparam int DEF_COLS = 1024;

    // fixed field widths
    localparam int OP_W  = 2;
    localparam int A_W   = 21;
    localparam int B_W   = 11;
    localparam int VAL_W = 21;
    localparam int POS_W = 11;

    // operation codes
    localparam logic [OP_W-1:0] OP_SWAP_ROW = 2'd0;
    localparam logic [OP_W-1:0] OP_SWAP_COL = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND     = 2'd3;

    // commands to one axis store
    typedef struct packed {
        logic swap;
        logic rd_fwd;
        logic rd_inv;
        logic init;
    } axis_ctl_t;

endpackage

// ----- design/rcp_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcp_axis
// Forward and inverse map memories of one axis, with the swap sequencer
// and the identity fill used by the clearing pass.
// ----------------------------------------------------------------------------
module rcp_axis #(
    parameter int DEPTH = rcp_pkg::DEF_ROWS,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rcp_pkg::axis_ctl_t ctl,
    input  logic [AW-1:0]     addr_s,
    input  logic [AW-1:0]     addr_t,
    output logic [AW-1:0]     fwd_rdata_a,
    output logic [AW-1:0]     fwd_rdata_b,
    output logic [AW-1:0]     inv_rdata
);
    import rcp_pkg::*;

    logic [AW-1:0] fwd_mem [DEPTH];
    logic [AW-1:0] inv_mem [DEPTH];

    logic          ph1_reg;
    logic          ph2_reg;
    logic [AW-1:0] s_reg;
    logic [AW-1:0] t_reg;
    logic [AW-1:0] fwd_rd_a_reg;
    logic [AW-1:0] fwd_rd_b_reg;
    logic [AW-1:0] inv_rd_reg;

    logic          mem_we;
    logic [AW-1:0] fwd_wa;
    logic [AW-1:0] fwd_wd;
    logic [AW-1:0] inv_wa;
    logic [AW-1:0] inv_wd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph1_reg <= 1'b0;
            ph2_reg <= 1'b0;
        end
        else
        begin
            ph1_reg <= ctl.swap;
            ph2_reg <= ph1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.swap)
        begin
            s_reg <= addr_s;
            t_reg <= addr_t;
        end
    end

    // first write moves line t into slot s, second moves line s into slot t;
    // the read registers hold both lines until the next read
    always_comb
    begin
        mem_we = ctl.init || ph1_reg || ph2_reg;
        if (ctl.init)
        begin
            fwd_wa = addr_s;
            fwd_wd = addr_s;
            inv_wa = addr_s;
            inv_wd = addr_s;
        end
        else if (ph1_reg)
        begin
            fwd_wa = s_reg;
            fwd_wd = fwd_rd_b_reg;
            inv_wa = fwd_rd_b_reg;
            inv_wd = s_reg;
        end
        else
        begin
            fwd_wa = t_reg;
            fwd_wd = fwd_rd_a_reg;
            inv_wa = fwd_rd_a_reg;
            inv_wd = t_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fwd_mem[fwd_wa] <= fwd_wd;
        end
        if (ctl.swap || ctl.rd_fwd)
        begin
            fwd_rd_a_reg <= fwd_mem[addr_s];
            fwd_rd_b_reg <= fwd_mem[addr_t];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            inv_mem[inv_wa] <= inv_wd;
        end
        if (ctl.rd_inv)
        begin
            inv_rd_reg <= inv_mem[addr_s];
        end
    end

    assign fwd_rdata_a = fwd_rd_a_reg;
    assign fwd_rdata_b = fwd_rd_b_reg;
    assign inv_rdata   = inv_rd_reg;

endmodule

// ----- design/rcp_divc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcp_divc
// Three-stage divide of a value by a constant: reciprocal multiply,
// back multiply, then one compare-and-subtract correction.
// ----------------------------------------------------------------------------
module rcp_divc #(
    parameter int DIVISOR = rcp_pkg::DEF_COLS,
    localparam int RW = $clog2(DIVISOR)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rcp_pkg::VAL_W-1:0] x,
    output logic                      done,
    output logic [rcp_pkg::VAL_W-1:0] quot,
    output logic [RW-1:0]             rem
);
    import rcp_pkg::*;

    localparam int PW = VAL_W + 32;
    localparam logic [31:0]      RECIP = 32'((64'd1 << 32) / DIVISOR);
    localparam logic [VAL_W-1:0] DIV_C = VAL_W'(DIVISOR);

    logic             v1_reg;
    logic             v2_reg;
    logic             done_reg;
    logic [VAL_W-1:0] x1_reg;
    logic [VAL_W-1:0] x2_reg;
    logic [PW-1:0]    prod_reg;
    logic [VAL_W-1:0] qe_reg;
    logic [VAL_W-1:0] qd_reg;
    logic [VAL_W-1:0] quot_reg;
    logic [RW-1:0]    rem_reg;

    logic [VAL_W-1:0] qe;
    logic [VAL_W-1:0] r_raw;

    // estimate is the true quotient or one below it
    assign qe    = prod_reg[PW-1:32];
    assign r_raw = x2_reg - qd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg   <= x;
        prod_reg <= PW'(x) * PW'(RECIP);
        x2_reg   <= x1_reg;
        qe_reg   <= qe;
        qd_reg   <= qe * DIV_C;
        if (r_raw >= DIV_C)
        begin
            quot_reg <= qe_reg + VAL_W'(1);
            rem_reg  <= RW'(r_raw - DIV_C);
        end
        else
        begin
            quot_reg <= qe_reg;
            rem_reg  <= RW'(r_raw);
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ----- design/row_col_permutation_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_col_permutation_table
// Row and column permutations of a grid, each with its inverse map.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. After reset the
// block runs a clearing pass that loads identity into all four maps, with
// busy high. A row or column swap holds busy after the accepting edge while
// the two map writes go through the single write port of each memory, and
// gives no result. A query gives its result after a map read, a row times
// COLS multiply and an add; a find gives its result after a three-stage
// divide by COLS and an inverse map read. An operand out of range gives a
// result flagged bad_operand in the cycle after acceptance, and busy does
// not rise for it. For a query or a find, busy falls in the cycle the result
// shows. Results are held for one cycle with done high and cannot be
// stalled.
// ----------------------------------------------------------------------------
module row_col_permutation_table #(
    parameter int ROWS = rcp_pkg::DEF_ROWS,
    parameter int COLS = rcp_pkg::DEF_COLS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rcp_pkg::OP_W-1:0]  opcode,
    input  logic [rcp_pkg::A_W-1:0]   operand_a,
    input  logic [rcp_pkg::B_W-1:0]   operand_b,
    output logic                      done,
    output logic [rcp_pkg::VAL_W-1:0] cell_value,
    output logic [rcp_pkg::POS_W-1:0] found_row,
    output logic [rcp_pkg::POS_W-1:0] found_col,
    output logic                      bad_operand
);
    import rcp_pkg::*;

    localparam int RAW   = $clog2(ROWS);
    localparam int CAW   = $clog2(COLS);
    localparam int MAXD  = (ROWS > COLS) ? ROWS : COLS;
    localparam int CNT_W = $clog2(MAXD);
    localparam logic [31:0] ROWS_L  = 32'(ROWS);
    localparam logic [31:0] COLS_L  = 32'(COLS);
    localparam logic [31:0] TOTAL_L = 32'(ROWS * COLS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAXD - 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SWAP1 = 3'd2;
    localparam logic [2:0] S_SWAP2 = 3'd3;
    localparam logic [2:0] S_QREAD = 3'd4;
    localparam logic [2:0] S_QSUM  = 3'd5;
    localparam logic [2:0] S_FDIV  = 3'd6;
    localparam logic [2:0] S_FREAD = 3'd7;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] init_cnt_reg;

    logic             accept;
    logic [A_W-1:0]   a_m1;
    logic [B_W-1:0]   b_m1;
    logic             a_row_ok;
    logic             b_row_ok;
    logic             a_col_ok;
    logic             b_col_ok;
    logic             a_find_ok;
    logic             bad;
    logic             go;

    axis_ctl_t        row_ctl;
    axis_ctl_t        col_ctl;
    logic [RAW-1:0]   row_addr_s;
    logic [RAW-1:0]   row_addr_t;
    logic [CAW-1:0]   col_addr_s;
    logic [CAW-1:0]   col_addr_t;
    logic [RAW-1:0]   row_fwd_a;
    logic [RAW-1:0]   row_fwd_b;
    logic [RAW-1:0]   row_inv;
    logic [CAW-1:0]   col_fwd_a;
    logic [CAW-1:0]   col_fwd_b;
    logic [CAW-1:0]   col_inv;

    logic             div_start;
    logic             div_done;
    logic [VAL_W-1:0] div_quot;
    logic [CAW-1:0]   div_rem;

    logic [VAL_W-1:0] prod_reg;
    logic [CAW-1:0]   colq_reg;

    logic             done_reg;
    logic             done_next;
    logic [VAL_W-1:0] cell_value_reg;
    logic [VAL_W-1:0] cell_value_next;
    logic [POS_W-1:0] found_row_reg;
    logic [POS_W-1:0] found_row_next;
    logic [POS_W-1:0] found_col_reg;
    logic [POS_W-1:0] found_col_next;
    logic             bad_reg;
    logic             bad_next;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign a_m1   = operand_a - A_W'(1);
    assign b_m1   = operand_b - B_W'(1);

    assign a_row_ok  = (operand_a != '0) && (32'(operand_a) <= ROWS_L);
    assign b_row_ok  = (operand_b != '0) && (32'(operand_b) <= ROWS_L);
    assign a_col_ok  = (operand_a != '0) && (32'(operand_a) <= COLS_L);
    assign b_col_ok  = (operand_b != '0) && (32'(operand_b) <= COLS_L);
    assign a_find_ok = (operand_a != '0) && (32'(operand_a) <= TOTAL_L);

    always_comb
    begin
        unique case (opcode)
            OP_SWAP_ROW: bad = !(a_row_ok && b_row_ok);
            OP_SWAP_COL: bad = !(a_col_ok && b_col_ok);
            OP_QUERY:    bad = !(a_row_ok && b_col_ok);
            OP_FIND:     bad = !a_find_ok;
            default:     bad = 1'b1;
        endcase
    end

    assign go        = accept && !bad;
    assign div_start = go && (opcode == OP_FIND);

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (init_cnt_reg == CNT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (go)
                begin
                    unique case (opcode) inside
                        OP_SWAP_ROW, OP_SWAP_COL: state_next = S_SWAP1;
                        OP_QUERY:                 state_next = S_QREAD;
                        OP_FIND:                  state_next = S_FDIV;
                        default:                  state_next = S_IDLE;
                    endcase
                end
            end
            S_SWAP1: state_next = S_SWAP2;
            S_SWAP2: state_next = S_IDLE;
            S_QREAD: state_next = S_QSUM;
            S_QSUM:  state_next = S_IDLE;
            S_FDIV:
            begin
                if (div_done)
                begin
                    state_next = S_FREAD;
                end
            end
            S_FREAD: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            init_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == S_INIT)
            begin
                init_cnt_reg <= init_cnt_reg + CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // map commands and addresses
    // ------------------------------------------------------------------
    always_comb
    begin
        row_ctl.swap   = go && (opcode == OP_SWAP_ROW);
        row_ctl.rd_fwd = go && (opcode == OP_QUERY);
        row_ctl.rd_inv = (state_reg == S_FDIV) && div_done;
        row_ctl.init   = (state_reg == S_INIT) && (32'(init_cnt_reg) < ROWS_L);

        col_ctl.swap   = go && (opcode == OP_SWAP_COL);
        col_ctl.rd_fwd = go && (opcode == OP_QUERY);
        col_ctl.rd_inv = (state_reg == S_FDIV) && div_done;
        col_ctl.init   = (state_reg == S_INIT) && (32'(init_cnt_reg) < COLS_L);
    end

    always_comb
    begin
        if (state_reg == S_INIT)
        begin
            row_addr_s = RAW'(init_cnt_reg);
            col_addr_s = CAW'(init_cnt_reg);
        end
        else if (state_reg == S_FDIV)
        begin
            row_addr_s = RAW'(div_quot);
            col_addr_s = div_rem;
        end
        else
        begin
            row_addr_s = RAW'(a_m1);
            // a query reads its column from the second operand
            col_addr_s = (opcode == OP_SWAP_COL) ? CAW'(a_m1) : CAW'(b_m1);
        end
        row_addr_t = RAW'(b_m1);
        col_addr_t = CAW'(b_m1);
    end

    rcp_axis #(
        .DEPTH (ROWS)
    ) u_row_axis (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (row_ctl),
        .addr_s      (row_addr_s),
        .addr_t      (row_addr_t),
        .fwd_rdata_a (row_fwd_a),
        .fwd_rdata_b (row_fwd_b),
        .inv_rdata   (row_inv)
    );

    rcp_axis #(
        .DEPTH (COLS)
    ) u_col_axis (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (col_ctl),
        .addr_s      (col_addr_s),
        .addr_t      (col_addr_t),
        .fwd_rdata_a (col_fwd_a),
        .fwd_rdata_b (col_fwd_b),
        .inv_rdata   (col_inv)
    );

    rcp_divc #(
        .DIVISOR (COLS)
    ) u_divc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (a_m1),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    // ------------------------------------------------------------------
    // query datapath and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == S_QREAD)
        begin
            prod_reg <= VAL_W'(32'(row_fwd_a) * COLS_L);
            colq_reg <= col_fwd_a;
        end
    end

    always_comb
    begin
        done_next       = 1'b0;
        bad_next        = 1'b0;
        cell_value_next = '0;
        found_row_next  = '0;
        found_col_next  = '0;
        if (accept && bad)
        begin
            done_next = 1'b1;
            bad_next  = 1'b1;
        end
        else if (state_reg == S_QSUM)
        begin
            done_next       = 1'b1;
            cell_value_next = prod_reg + VAL_W'(colq_reg) + VAL_W'(1);
        end
        else if (state_reg == S_FREAD)
        begin
            done_next      = 1'b1;
            found_row_next = POS_W'(32'(row_inv) + 32'd1);
            found_col_next = POS_W'(32'(col_inv) + 32'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            cell_value_reg <= cell_value_next;
            found_row_reg  <= found_row_next;
            found_col_reg  <= found_col_next;
            bad_reg        <= bad_next;
        end
    end

    assign done        = done_reg;
    assign cell_value  = cell_value_reg;
    assign found_row   = found_row_reg;
    assign found_col   = found_col_reg;
    assign bad_operand = bad_reg;

endmodule

// ----- design/rcp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcp_checker
// Port-level checks for the row/column permutation table, bound to the top.
// ----------------------------------------------------------------------------
module rcp_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [rcp_pkg::OP_W-1:0]  opcode,
    input logic [rcp_pkg::A_W-1:0]   operand_a,
    input logic                      done,
    input logic [rcp_pkg::VAL_W-1:0] cell_value,
    input logic [rcp_pkg::POS_W-1:0] found_row,
    input logic [rcp_pkg::POS_W-1:0] found_col,
    input logic                      bad_operand
);
    import rcp_pkg::*;

    logic accept;

    assign accept = start && !busy;

    // an error beat carries nothing but the flag
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_operand) |->
            (cell_value == '0) && (found_row == '0) && (found_col == '0))
        else $error("error beat with nonzero payload");

    // no beat without a command taken or in flight
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result beat without a pending command");

    // find of value zero is rejected on the next cycle
    a_find_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_FIND) && (operand_a == '0)) |=>
            (done && bad_operand))
        else $error("find of zero not rejected");

    // a swap either keeps the block busy or is rejected at once
    a_swap_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((opcode == OP_SWAP_ROW) || (opcode == OP_SWAP_COL))) |=>
            (busy || (done && bad_operand)))
        else $error("swap neither running nor rejected");

endmodule

bind row_col_permutation_table rcp_checker u_rcp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .operand_a   (operand_a),
    .done        (done),
    .cell_value  (cell_value),
    .found_row   (found_row),
    .found_col   (found_col),
    .bad_operand (bad_operand)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the row/column permutation table. Commands are
// queued by an initial block and fed by a clocked driver with random gaps.
// A local copy of the four slot maps predicts every query, find and operand
// error. A clocked monitor compares each done beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import rcp_pkg::*;

    localparam int ROWS = DEF_ROWS;
    localparam int COLS = DEF_COLS;
    localparam int RANDOM_CMDS = 1100;
    localparam int TIMEOUT_NS = 5_000_000;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [A_W-1:0]  a;
        logic [B_W-1:0]  b;
    } command_t;

    typedef struct {
        logic [VAL_W-1:0] cell_value;
        logic [POS_W-1:0] found_row;
        logic [POS_W-1:0] found_col;
        logic             bad_operand;
    } reply_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [OP_W-1:0]  opcode = '0;
    logic [A_W-1:0]   operand_a = '0;
    logic [B_W-1:0]   operand_b = '0;
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] cell_value;
    logic [POS_W-1:0] found_row;
    logic [POS_W-1:0] found_col;
    logic             bad_operand;

    // local copy of the slot maps
    logic [9:0] line_in_row_slot [ROWS];
    logic [9:0] row_slot_of_line [ROWS];
    logic [9:0] line_in_col_slot [COLS];
    logic [9:0] col_slot_of_line [COLS];

    command_t cmd_queue[$];
    reply_t   expected_replies[$];

    int n_accepted = 0;
    int n_replies = 0;
    int n_mismatch = 0;
    int n_swaps = 0;
    int n_queries = 0;
    int n_finds = 0;
    int n_rejects = 0;

    row_col_permutation_table #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .done       (done),
        .cell_value (cell_value),
        .found_row  (found_row),
        .found_col  (found_col),
        .bad_operand(bad_operand)
    );

    always #5 clk = ~clk;

    // updates the local maps and queues the reply a command should give
    function automatic void apply_command(input command_t c);
        reply_t      r;
        int unsigned a;
        int unsigned b;
        int unsigned lim;
        int unsigned v;
        logic [9:0]  ls;
        logic [9:0]  lt;
        r = '{default: '0};
        a = c.a;
        b = c.b;
        case (c.op) inside
            OP_SWAP_ROW, OP_SWAP_COL:
            begin
                lim = (c.op == OP_SWAP_ROW) ? ROWS : COLS;
                if (a < 1 || a > lim || b < 1 || b > lim)
                begin
                    r.bad_operand = 1'b1;
                    expected_replies.push_back(r);
                    n_rejects++;
                end
                else if (c.op == OP_SWAP_ROW)
                begin
                    ls = line_in_row_slot[a-1];
                    lt = line_in_row_slot[b-1];
                    row_slot_of_line[lt] = 10'(a - 1);
                    row_slot_of_line[ls] = 10'(b - 1);
                    line_in_row_slot[a-1] = lt;
                    line_in_row_slot[b-1] = ls;
                    n_swaps++;
                end
                else
                begin
                    ls = line_in_col_slot[a-1];
                    lt = line_in_col_slot[b-1];
                    col_slot_of_line[lt] = 10'(a - 1);
                    col_slot_of_line[ls] = 10'(b - 1);
                    line_in_col_slot[a-1] = lt;
                    line_in_col_slot[b-1] = ls;
                    n_swaps++;
                end
            end
            OP_QUERY:
            begin
                if (a < 1 || a > ROWS || b < 1 || b > COLS)
                begin
                    r.bad_operand = 1'b1;
                    n_rejects++;
                end
                else
                begin
                    v = COLS * line_in_row_slot[a-1] + line_in_col_slot[b-1] + 1;
                    r.cell_value = VAL_W'(v);
                    n_queries++;
                end
                expected_replies.push_back(r);
            end
            default:
            begin
                // operand_b plays no part in a find
                if (a < 1 || a > ROWS * COLS)
                begin
                    r.bad_operand = 1'b1;
                    n_rejects++;
                end
                else
                begin
                    r.found_row = POS_W'(row_slot_of_line[(a - 1) / COLS] + 1);
                    r.found_col = POS_W'(col_slot_of_line[(a - 1) % COLS] + 1);
                    n_finds++;
                end
                expected_replies.push_back(r);
            end
        endcase
    endfunction

    // driver: a beat is taken when start is high and busy is low
    always @(posedge clk)
    begin
        command_t c;
        logic     fire;
        logic     hold_off;
        if (!rst_n)
        begin
            start <= 1'b0;
            opcode <= '0;
            operand_a <= '0;
            operand_b <= '0;
        end
        else
        begin
            fire = start && !busy;
            if (fire)
            begin
                apply_command('{op: opcode, a: operand_a, b: operand_b});
                n_accepted++;
            end
            if (!start || fire)
            begin
                // no gaps at all in the middle stretch
                hold_off = (n_accepted < 500 || n_accepted >= 700)
                           && ($urandom_range(99) < 34);
                if (cmd_queue.size() > 0 && !hold_off)
                begin
                    c = cmd_queue.pop_front();
                    start <= 1'b1;
                    opcode <= c.op;
                    operand_a <= c.a;
                    operand_b <= c.b;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: done lasts one cycle and cannot be stalled
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done)
        begin
            n_replies++;
            if (expected_replies.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected beat: value %0d row %0d col %0d bad %0b",
                             cell_value, found_row, found_col, bad_operand);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (cell_value !== want.cell_value || found_row !== want.found_row ||
                    found_col !== want.found_col || bad_operand !== want.bad_operand)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                    begin
                        $write("beat %0d mismatch: exp value %0d row %0d col %0d bad %0b, ",
                               n_replies, want.cell_value, want.found_row,
                               want.found_col, want.bad_operand);
                        $display("got value %0d row %0d col %0d bad %0b",
                                 cell_value, found_row, found_col, bad_operand);
                    end
                end
            end
        end
    end

    // slot index biased toward both ends so swaps pile up on a few lines
    function automatic int unsigned pick_slot(input int unsigned lim);
        int unsigned r;
        r = $urandom_range(9);
        if (r < 4)
            return $urandom_range(6, 1);
        else if (r < 6)
            return $urandom_range(lim, lim - 5);
        return $urandom_range(lim, 1);
    endfunction

    function automatic void add_cmd(input logic [OP_W-1:0] op, input int unsigned a,
                                    input int unsigned b);
        cmd_queue.push_back('{op: op, a: A_W'(a), b: B_W'(b)});
    endfunction

    initial
    begin
        int unsigned sel;
        int unsigned a;
        int unsigned b;
        for (int i = 0; i < ROWS; i++)
        begin
            line_in_row_slot[i] = 10'(i);
            row_slot_of_line[i] = 10'(i);
        end
        for (int i = 0; i < COLS; i++)
        begin
            line_in_col_slot[i] = 10'(i);
            col_slot_of_line[i] = 10'(i);
        end

        // corners, identity lookups and rejected operands of each command kind
        add_cmd(OP_QUERY, 1, 1);
        add_cmd(OP_QUERY, ROWS, COLS);
        add_cmd(OP_QUERY, 1, COLS);
        add_cmd(OP_FIND, 1, 0);
        add_cmd(OP_FIND, ROWS * COLS, 2047);
        add_cmd(OP_SWAP_ROW, 1, ROWS);
        add_cmd(OP_SWAP_COL, COLS, 1);
        add_cmd(OP_SWAP_ROW, 5, 5);
        add_cmd(OP_SWAP_COL, 7, 7);
        add_cmd(OP_QUERY, 1, 1);
        add_cmd(OP_QUERY, ROWS, 1);
        add_cmd(OP_FIND, 1, 1);
        add_cmd(OP_FIND, ROWS * COLS, 0);
        add_cmd(OP_FIND, 0, 5);
        add_cmd(OP_FIND, ROWS * COLS + 1, 5);
        add_cmd(OP_FIND, 2097151, 2047);
        add_cmd(OP_SWAP_ROW, 0, 3);
        add_cmd(OP_SWAP_ROW, 3, ROWS + 1);
        add_cmd(OP_SWAP_COL, COLS + 1, 2);
        add_cmd(OP_SWAP_COL, 2, 0);
        add_cmd(OP_SWAP_ROW, 2097151, 2047);
        add_cmd(OP_QUERY, 0, 1);
        add_cmd(OP_QUERY, ROWS + 1, 1);
        add_cmd(OP_QUERY, 1, 0);
        add_cmd(OP_QUERY, 1, 2047);

        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 12)
            begin
                // noise: mostly out of range, any opcode
                a = ($urandom_range(3) == 0) ? 0 : $urandom_range(2097151);
                add_cmd(OP_W'($urandom_range(3)), a, $urandom_range(2047));
            end
            else if (sel < 40)
                add_cmd(OP_SWAP_ROW, pick_slot(ROWS), pick_slot(ROWS));
            else if (sel < 60)
                add_cmd(OP_SWAP_COL, pick_slot(COLS), pick_slot(COLS));
            else if (sel < 80)
                add_cmd(OP_QUERY, pick_slot(ROWS), pick_slot(COLS));
            else
            begin
                if ($urandom_range(3) == 0)
                    a = $urandom_range(ROWS * COLS, 1);
                else
                    a = (pick_slot(ROWS) - 1) * COLS + pick_slot(COLS);
                add_cmd(OP_FIND, a, $urandom_range(2047));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (cmd_queue.size() > 0 || start || busy || expected_replies.size() > 0);
        repeat (20) @(posedge clk);

        $display("ran %0d commands: %0d swaps, %0d queries, %0d finds, %0d rejected",
                 n_accepted, n_swaps, n_queries, n_finds, n_rejects);
        $display("checked %0d result beats, %0d mismatches, %0d left waiting",
                 n_replies, n_mismatch, expected_replies.size());
        if (n_mismatch == 0 && expected_replies.size() == 0)
            $display("[row_col_permutation_table] OK");
        else
            $display("[row_col_permutation_table] ERROR");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d commands queued and %0d results outstanding",
                 cmd_queue.size(), expected_replies.size());
        $display("[row_col_permutation_table] ERROR");
        $finish;
    end

endmodule
